// File: rtl/bhi_pkg.sv
// bhi_pkg: word types and constants for the barycentric height interpolation core.
// No dependencies; imported by rtl/barycentric_height_interp_core.sv and tb/sv/tb_top.sv.
package bhi_pkg;

  typedef struct packed {
    logic signed [31:0] point_x;
    logic signed [31:0] point_z;
    logic signed [31:0] first_x;
    logic signed [31:0] first_y;
    logic signed [31:0] first_z;
    logic signed [31:0] second_x;
    logic signed [31:0] second_y;
    logic signed [31:0] second_z;
    logic signed [31:0] third_x;
    logic signed [31:0] third_y;
    logic signed [31:0] third_z;
  } query_t;

  typedef struct packed {
    logic signed [31:0] height;
    logic               degenerate;
    logic               overflowed;
  } result_t;

  // Quotient bits resolved by the divider; a larger quotient saturates anyway.
  localparam int QBITS = 33;

  // Restoring-divider stage word.
  typedef struct packed {
    logic [100:0]       rem;
    logic [66:0]        dv;
    logic [QBITS-1:0]   quo;
    logic signed [31:0] ay;
    logic               neg;
    logic               degen;
    logic               ovf;
  } div_t;

  localparam logic signed [31:0] HMAX = 32'sh7fffffff;
  localparam logic signed [31:0] HMIN = 32'sh80000000;

endpackage

// File: rtl/barycentric_height_interp_core.sv
// barycentric_height_interp_core: pipelined barycentric height interpolation.
// Depends on rtl/bhi_pkg.sv (word types, divider stage word, limits).
//
//   channel  | handshake          | word
//   ---------+--------------------+-----------------------------------------
//   query    | start / busy       | query_t: point (x,z), three vertices
//   result   | done (one cycle)   | result_t: height, degenerate, overflowed
//
// One query enters per cycle. The depth is set by the 33-stage restoring
// divider (one quotient bit per stage), behind 9 stages of differences,
// products and magnitudes, and 2 stages of final add and saturation.
// Reset clears the valid pipeline only; data registers are left as is.
// busy is always low and the receiver cannot stall, so the pipeline never
// stops.
module barycentric_height_interp_core
  import bhi_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  output logic    busy,
  input  query_t  query,
  output logic    done,
  output result_t result
);

  localparam int LAT = 9 + QBITS + 2;

  // Valid bits travel alongside the data, one per register level.
  logic [LAT-1:0] vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[LAT-2:0], start & ~busy};
    end
  end

  assign busy = 1'b0;

  // Stage 1: edge vectors relative to the first vertex, and height deltas.
  logic signed [32:0] e0x, e0z, e1x, e1z, e2x, e2z, dby, dcy;
  logic signed [31:0] ay1;

  always_ff @(posedge clk) begin
    e0x <= {query.second_x[31], query.second_x} - {query.first_x[31], query.first_x};
    e0z <= {query.second_z[31], query.second_z} - {query.first_z[31], query.first_z};
    e1x <= {query.third_x[31], query.third_x} - {query.first_x[31], query.first_x};
    e1z <= {query.third_z[31], query.third_z} - {query.first_z[31], query.first_z};
    e2x <= {query.point_x[31], query.point_x} - {query.first_x[31], query.first_x};
    e2z <= {query.point_z[31], query.point_z} - {query.first_z[31], query.first_z};
    dby <= {query.second_y[31], query.second_y} - {query.first_y[31], query.first_y};
    dcy <= {query.third_y[31], query.third_y} - {query.first_y[31], query.first_y};
    ay1 <= query.first_y;
  end

  // Stage 2: the six cross-product terms, one 33x33 multiply each.
  logic signed [65:0] p_d0, p_d1, p_v0, p_v1, p_w0, p_w1;
  logic signed [32:0] dby2, dcy2;
  logic signed [31:0] ay2;

  always_ff @(posedge clk) begin
    p_d0 <= e0x * e1z;
    p_d1 <= e0z * e1x;
    p_v0 <= e2x * e1z;
    p_v1 <= e2z * e1x;
    p_w0 <= e0x * e2z;
    p_w1 <= e0z * e2x;
    dby2 <= dby;
    dcy2 <= dcy;
    ay2  <= ay1;
  end

  // Stage 3: denominator and the two weight numerators.
  logic signed [66:0] den3, vn3, wn3;
  logic signed [32:0] dby3, dcy3;
  logic signed [31:0] ay3;

  always_ff @(posedge clk) begin
    den3 <= 67'(p_d0) - 67'(p_d1);
    vn3  <= 67'(p_v0) - 67'(p_v1);
    wn3  <= 67'(p_w0) - 67'(p_w1);
    dby3 <= dby2;
    dcy3 <= dcy2;
    ay3  <= ay2;
  end

  // Stage 4: split each 67-bit weight into a signed high half and an
  // unsigned low half so every multiply stays near 34x33.
  logic signed [65:0] pvh, pwh;
  logic signed [67:0] pvl, pwl;
  logic signed [66:0] den4;
  logic signed [31:0] ay4;

  always_ff @(posedge clk) begin
    pvh  <= $signed(vn3[66:34]) * dby3;
    pvl  <= $signed({1'b0, vn3[33:0]}) * dby3;
    pwh  <= $signed(wn3[66:34]) * dcy3;
    pwl  <= $signed({1'b0, wn3[33:0]}) * dcy3;
    den4 <= den3;
    ay4  <= ay3;
  end

  // Stage 5: recombine the partial products.
  logic signed [99:0] sv5, sw5;
  logic signed [66:0] den5;
  logic signed [31:0] ay5;

  always_ff @(posedge clk) begin
    sv5  <= (100'(pvh) <<< 34) + 100'(pvl);
    sw5  <= (100'(pwh) <<< 34) + 100'(pwl);
    den5 <= den4;
    ay5  <= ay4;
  end

  // Stage 6: full numerator.
  logic signed [99:0] num6;
  logic signed [66:0] den6;
  logic signed [31:0] ay6;

  always_ff @(posedge clk) begin
    num6 <= sv5 + sw5;
    den6 <= den5;
    ay6  <= ay5;
  end

  // Stage 7: magnitudes and the quotient sign; flag a zero denominator.
  logic [98:0]        nmag7;
  logic [65:0]        dmag7;
  logic               neg7, degen7;
  logic signed [31:0] ay7;

  always_ff @(posedge clk) begin
    nmag7  <= num6[99] ? 99'(-num6) : 99'(num6);
    dmag7  <= den6[66] ? 66'(-den6) : 66'(den6);
    neg7   <= num6[99] ^ den6[66];
    degen7 <= (den6 == '0);
    ay7    <= ay6;
  end

  // Stage 8: round to nearest, ties away from zero: (2|N| + |D|) / (2|D|).
  logic [100:0]       np8;
  logic [66:0]        dp8;
  logic               neg8, degen8;
  logic signed [31:0] ay8;

  always_ff @(posedge clk) begin
    np8    <= {1'b0, nmag7, 1'b0} + 101'(dmag7);
    dp8    <= {dmag7, 1'b0};
    neg8   <= neg7;
    degen8 <= degen7;
    ay8    <= ay7;
  end

  // Stage 9: a quotient of 2^33 or more saturates whatever the vertex height.
  div_t dstg [0:QBITS];

  always_ff @(posedge clk) begin
    dstg[0].rem   <= np8;
    dstg[0].dv    <= dp8;
    dstg[0].quo   <= '0;
    dstg[0].ay    <= ay8;
    dstg[0].neg   <= neg8;
    dstg[0].degen <= degen8;
    dstg[0].ovf   <= (np8 >= {1'b0, dp8, {QBITS{1'b0}}});
  end

  // Divider: one quotient bit per stage, most significant first.
  for (genvar k = 1; k <= QBITS; k++) begin : g_div
    localparam int BIT = QBITS - k;
    logic [100:0] shifted;
    logic [101:0] trial;
    div_t         stg_next;

    assign shifted = 101'(dstg[k-1].dv) << BIT;
    assign trial   = {1'b0, dstg[k-1].rem} - {1'b0, shifted};

    always_comb begin
      stg_next = dstg[k-1];
      if (!trial[101]) begin
        stg_next.rem      = trial[100:0];
        stg_next.quo[BIT] = 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      dstg[k] <= stg_next;
    end
  end

  // Final add: first_y plus the signed rounded quotient.
  logic signed [34:0] sum_a;
  logic               neg_a, degen_a, ovf_a;

  always_ff @(posedge clk) begin
    sum_a   <= 35'(dstg[QBITS].ay) + (dstg[QBITS].neg ? -35'({1'b0, dstg[QBITS].quo})
                                                      : 35'({1'b0, dstg[QBITS].quo}));
    neg_a   <= dstg[QBITS].neg;
    degen_a <= dstg[QBITS].degen;
    ovf_a   <= dstg[QBITS].ovf;
  end

  // Output register: saturate, or force zero height on a degenerate triangle.
  result_t res_next;

  always_comb begin
    res_next.degenerate = degen_a;
    res_next.overflowed = 1'b0;
    res_next.height     = sum_a[31:0];
    if (degen_a) begin
      res_next.height = '0;
    end else if (ovf_a) begin
      res_next.overflowed = 1'b1;
      res_next.height     = neg_a ? HMIN : HMAX;
    end else if (sum_a > 35'(HMAX)) begin
      res_next.overflowed = 1'b1;
      res_next.height     = HMAX;
    end else if (sum_a < 35'(HMIN)) begin
      res_next.overflowed = 1'b1;
      res_next.height     = HMIN;
    end
  end

  always_ff @(posedge clk) begin
    result <= res_next;
  end

  assign done = vld[LAT-1];

`ifndef SYNTHESIS
  a_latency: assert property (@(posedge clk) disable iff (rst)
    start |-> ##LAT done) else $error("result missing after fixed latency");
  a_flags: assert property (@(posedge clk) disable iff (rst)
    done |-> !(result.degenerate && result.overflowed))
    else $error("degenerate and overflowed both set");
  a_degen_zero: assert property (@(posedge clk) disable iff (rst)
    (done && result.degenerate) |-> (result.height == '0))
    else $error("degenerate result with nonzero height");
  a_sat: assert property (@(posedge clk) disable iff (rst)
    (done && result.overflowed) |-> (result.height == HMAX || result.height == HMIN))
    else $error("overflow flagged without saturated height");
`endif

endmodule

// File: tb/sv/tb_top.sv
// tb_top: self-checking bench for barycentric_height_interp_core.
// Depends on rtl/bhi_pkg.sv (query_t, result_t) and the core itself.
`timescale 1ns / 1ps

module tb_top;
  import bhi_pkg::*;

  logic    clk;
  logic    rst;
  logic    start;
  logic    busy;
  query_t  query;
  logic    done;
  result_t result;

  barycentric_height_interp_core u_top (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .query  (query),
    .done   (done),
    .result (result)
  );

  query_t  pending_queries[$];
  result_t expected_heights[$];
  int      mismatch_count = 0;
  int      idle_percent;
  bit      stim_done;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Exact height: first_y + round(N / D), ties away from zero, saturated.
  function automatic result_t interp_height(query_t q);
    result_t r;
    logic signed [33:0]  e0x, e0z, e1x, e1z, e2x, e2z, dby, dcy;
    logic signed [127:0] den, vn, wn, num, nmag, dmag, quo, h;
    logic                neg;
    e0x = 34'(q.second_x) - 34'(q.first_x);
    e0z = 34'(q.second_z) - 34'(q.first_z);
    e1x = 34'(q.third_x) - 34'(q.first_x);
    e1z = 34'(q.third_z) - 34'(q.first_z);
    e2x = 34'(q.point_x) - 34'(q.first_x);
    e2z = 34'(q.point_z) - 34'(q.first_z);
    dby = 34'(q.second_y) - 34'(q.first_y);
    dcy = 34'(q.third_y) - 34'(q.first_y);
    den = 128'(e0x) * 128'(e1z) - 128'(e0z) * 128'(e1x);
    r = '0;
    if (den == 0) begin
      r.degenerate = 1'b1;
      return r;
    end
    vn = 128'(e2x) * 128'(e1z) - 128'(e2z) * 128'(e1x);
    wn = 128'(e0x) * 128'(e2z) - 128'(e0z) * 128'(e2x);
    num = vn * 128'(dby) + wn * 128'(dcy);
    neg = (num < 0) != (den < 0);
    nmag = num < 0 ? -num : num;
    dmag = den < 0 ? -den : den;
    quo = (2 * nmag + dmag) / (2 * dmag);
    if (quo == 0) neg = 1'b0;
    h = 128'(q.first_y) + (neg ? -quo : quo);
    if (h > 128'(HMAX)) begin
      r.height = HMAX;
      r.overflowed = 1'b1;
    end else if (h < 128'(HMIN)) begin
      r.height = HMIN;
      r.overflowed = 1'b1;
    end else begin
      r.height = h[31:0];
    end
    return r;
  endfunction

  function automatic logic [31:0] pick_coord();
    int sel;
    sel = $urandom_range(0, 9);
    case (sel)
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2, 3: return $urandom;
      default: return 32'($signed($urandom_range(0, 2000))) - 1000 << 12;
    endcase
  endfunction

  // Driver: present the next pending word at the falling edge.
  always @(negedge clk) begin
    if (rst) begin
      start <= 1'b0;
      query <= '0;
    end else if (start && !busy) begin
      void'(pending_queries.pop_front());
      if (pending_queries.size() > 0 && $urandom_range(0, 99) >= idle_percent) begin
        query <= pending_queries[0];
        expected_heights.push_back(interp_height(pending_queries[0]));
      end else begin
        start <= 1'b0;
      end
    end else if (!start && pending_queries.size() > 0 &&
                 $urandom_range(0, 99) >= idle_percent) begin
      start <= 1'b1;
      query <= pending_queries[0];
      expected_heights.push_back(interp_height(pending_queries[0]));
    end
  end

  // Monitor: compare each result word with the oldest expectation.
  always @(posedge clk) begin
    result_t want;
    if (!rst && done) begin
      if (expected_heights.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result word: height=%0d degen=%b ovf=%b",
                   result.height, result.degenerate, result.overflowed);
      end else begin
        want = expected_heights.pop_front();
        if (result.height !== want.height || result.degenerate !== want.degenerate ||
            result.overflowed !== want.overflowed) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("mismatch: expected h=%0d d=%b o=%b got h=%0d d=%b o=%b",
                     want.height, want.degenerate, want.overflowed,
                     result.height, result.degenerate, result.overflowed);
        end
      end
    end
  end

  task automatic add_query(input logic [31:0] px, pz, ax, ay, az, bx, by, bz,
                           cx, cy, cz);
    query_t q;
    q.point_x = px;  q.point_z = pz;
    q.first_x = ax;  q.first_y = ay;  q.first_z = az;
    q.second_x = bx; q.second_y = by; q.second_z = bz;
    q.third_x = cx;  q.third_y = cy;  q.third_z = cz;
    pending_queries.push_back(q);
  endtask

  initial begin
    query_t q;
    rst = 1'b1;
    idle_percent = 12;
    stim_done = 1'b0;
    // Directed: unit triangle, vertices, centroid, outside point.
    add_query(32'h4000, 32'h4000, 0, 32'h10000, 0, 32'h10000, 32'h20000, 0,
              0, 32'h30000, 32'h10000);
    add_query(0, 0, 0, 32'h10000, 0, 32'h10000, 32'h20000, 0, 0, 32'h30000, 32'h10000);
    add_query(32'h10000, 0, 0, 5, 0, 32'h10000, 7, 0, 0, 9, 32'h10000);
    add_query(32'h5555, 32'h5555, 0, 0, 0, 32'h10000, 32'h10000, 0, 0, 32'h20000,
              32'h10000);
    add_query(32'h50000, -32'sh30000, 0, 0, 0, 32'h10000, 32'h10000, 0, 0,
              32'h20000, 32'h10000);
    // Rounding tie: half step between heights 0 and 1.
    add_query(32'h8000, 0, 0, 0, 0, 32'h10000, 1, 0, 0, 0, 32'h10000);
    add_query(32'h8000, 0, 0, 0, 0, 32'h10000, -1, 0, 0, 0, 32'h10000);
    // Degenerate: collinear and coincident vertices.
    add_query(3, 4, 0, 9, 0, 32'h10000, 9, 32'h10000, 32'h20000, 9, 32'h20000);
    add_query(1, 2, 5, 6, 7, 5, 6, 7, 5, 6, 7);
    // Overflow both ways and extreme fields.
    add_query(32'h7fffffff, 32'h80000000, 0, 32'h7fffffff, 0, 1, 32'h80000000, 0,
              0, 32'h7fffffff, 1);
    add_query(32'h80000000, 32'h7fffffff, 0, 32'h80000000, 0, 1, 32'h7fffffff, 0,
              0, 32'h80000000, 1);
    add_query(32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000,
              32'h7fffffff, 32'h80000000, 32'h80000000, 32'h80000000, 32'h7fffffff,
              32'h7fffffff);
    add_query(32'h20000, 0, 0, 32'h7fff0000, 0, 32'h10000, 32'h7fff8000, 0, 0,
              32'h7fff0000, 32'h10000);
    add_query(32'h20000, 0, 0, 32'h80010000, 0, 32'h10000, 32'h80008000, 0, 0,
              32'h80010000, 32'h10000);
    add_query('1, '1, '1, '1, '1, 0, '1, '1, '1, '1, 0);
    for (int i = 0; i < 800; i++) begin
      if ($urandom_range(0, 19) == 0) begin
        // collinear vertices
        q.first_x = pick_coord(); q.first_z = pick_coord();
        q.second_x = q.first_x + 32'h10000; q.second_z = q.first_z + 32'h20000;
        q.third_x = q.first_x + 32'h30000;  q.third_z = q.first_z + 32'h60000;
      end else begin
        q.first_x = pick_coord();  q.first_z = pick_coord();
        q.second_x = pick_coord(); q.second_z = pick_coord();
        q.third_x = pick_coord();  q.third_z = pick_coord();
      end
      q.point_x = pick_coord(); q.point_z = pick_coord();
      q.first_y = pick_coord(); q.second_y = pick_coord(); q.third_y = pick_coord();
      pending_queries.push_back(q);
    end
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    // Hold idling off for a long stretch in the middle of the run.
    while (pending_queries.size() >= 500) @(posedge clk);
    idle_percent = 0;
    while (pending_queries.size() >= 250) @(posedge clk);
    idle_percent = 12;
    while (pending_queries.size() != 0) @(posedge clk);
    while (expected_heights.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (mismatch_count == 0)
      $display("** barycentric_height_interp_core: PASSED **");
    else
      $display("** barycentric_height_interp_core: FAILED **");
    $finish;
  end

  initial begin
    #5ms;
    $display("** barycentric_height_interp_core: FAILED **");
    $finish;
  end

endmodule

// File: files.f
rtl/bhi_pkg.sv
rtl/barycentric_height_interp_core.sv
tb/sv/tb_top.sv
